@@ rtl/core/vrt_pkg.sv @@
// Shared types and constants for the voxel ray traversal block.
package vrt_pkg;

  localparam int COORD_W = 32;  // Q16.16 coordinate
  localparam int GRID_W  = 20;  // grid size register
  localparam int GE_W    = 21;  // grid size / remainder, one bit of headroom
  localparam int KW      = 34;  // exact voxel key
  localparam int SPAN_W  = 36;  // |dkx|+|dky|+|dkz|
  localparam int ITER_W  = 37;  // 2*span+1
  localparam int T_W     = 64;  // crossing parameter, unsigned Q32.32
  localparam int OUT_W   = 23;  // voxel index field
  localparam int DNUM_W  = 53;  // divider dividend / quotient
  localparam int DDEN_W  = 33;  // divider divisor / remainder
  localparam int QDEPTH  = 2;

  localparam logic [GRID_W-1:0] GRID_RESET = 20'd13107;
  localparam logic [T_W-1:0]    T_NEVER    = {T_W{1'b1}};
  localparam logic [T_W-1:0]    T_ONE      = 64'h0000_0001_0000_0000;

  // one classified ray, handed from front to back
  typedef struct packed {
    logic                   empty;
    logic [SPAN_W-1:0]      span;
    logic [2:0][KW-1:0]     ks;
    logic [2:0][KW-1:0]     ke;
    logic [2:0]             neg;
    logic [2:0][T_W-1:0]    tmax;
    logic [2:0][T_W-1:0]    tdel;
  } entry_t;

endpackage

@@ rtl/core/vrt_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module vrt_div import vrt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DNUM_W-1:0] num,
  input  logic [DDEN_W-1:0] den,
  output logic              done,
  output logic [DNUM_W-1:0] quo,
  output logic [DDEN_W-1:0] rem
);

  localparam int CW = $clog2(DNUM_W + 1);

  logic [CW-1:0]     cnt;
  logic              busy;
  logic [DDEN_W-1:0] dvs;
  logic [DDEN_W:0]   trial;
  logic              fits;

  assign trial = {rem, quo[DNUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DNUM_W);
        quo  <= num;
        rem  <= '0;
        dvs  <= den;
      end else if (busy) begin
        rem <= fits ? DDEN_W'(trial - {1'b0, dvs}) : trial[DDEN_W-1:0];
        quo <= {quo[DNUM_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/core/vrt_front.sv @@
// Front end: takes a ray, quantizes both points and sets up the DDA per axis.
module vrt_front import vrt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [GRID_W-1:0]         voxel_edge,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] start_z,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  input  logic signed [COORD_W-1:0] end_z,
  output logic                      q_push,
  input  logic                      q_full,
  output entry_t                    q_data
);

  typedef enum logic [2:0] {F_IDLE, F_DIV_S, F_DIV_E, F_DIV_T, F_DIV_M, F_PUSH} fstate_t;

  fstate_t st;
  logic    go;
  logic    go_next;
  logic    div_done;
  logic [2:0][COORD_W-1:0] s;
  logic [2:0][COORD_W-1:0] e;
  logic [2:0][KW-1:0]      ks;
  logic [2:0][KW-1:0]      ke;
  logic [2:0][GE_W-1:0]    rs;
  logic [2:0][T_W-1:0]     tmax;
  logic [2:0][T_W-1:0]     tdel;

  logic [GE_W-1:0]         g;
  logic [2:0][DNUM_W-1:0]  dnum;
  logic [2:0][DDEN_W-1:0]  dden;
  logic [2:0]              ddone;
  logic [2:0][DNUM_W-1:0]  dquo;
  logic [2:0][DDEN_W-1:0]  drem;
  logic [2:0][KW-1:0]      key;
  logic [2:0][GE_W-1:0]    rfix;
  logic [2:0][KW-1:0]      dk;
  logic [2:0][KW-1:0]      dkabs;
  logic [2:0][DDEN_W-1:0]  dabs;
  logic [2:0][T_W-1:0]     tq;

  assign g        = (voxel_edge == '0) ? GE_W'(1) : {1'b0, voxel_edge};
  assign in_ready = (st == F_IDLE);
  assign q_push   = (st == F_PUSH) && !q_full;
  assign div_done = &ddone;
  assign go_next  = (st == F_IDLE && in_valid) ||
                    (div_done && (st == F_DIV_S || st == F_DIV_E || st == F_DIV_T));

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic              sgn;
    logic [COORD_W-1:0] src;
    logic [COORD_W-1:0] mag;
    logic [DDEN_W-1:0]  d;
    logic [GE_W-1:0]    r0;
    logic               nz;

    assign src = (st == F_DIV_E) ? e[a] : s[a];
    assign sgn = src[COORD_W-1];
    assign mag = sgn ? COORD_W'(~src + 1'b1) : src;
    assign d   = DDEN_W'({e[a][COORD_W-1], e[a]} - {s[a][COORD_W-1], s[a]});
    assign dabs[a]  = d[DDEN_W-1] ? DDEN_W'(~d + 1'b1) : d;
    assign dk[a]    = KW'(ke[a] - ks[a]);
    assign dkabs[a] = dk[a][KW-1] ? KW'(~dk[a] + 1'b1) : dk[a];

    // floor division fix-up for negative coordinates
    assign r0      = drem[a][GE_W-1:0];
    assign nz      = (r0 != '0);
    assign key[a]  = sgn ? KW'(~dquo[a][KW-1:0] + {{(KW-1){1'b0}}, !nz}) : dquo[a][KW-1:0];
    assign rfix[a] = !sgn ? r0 : (nz ? GE_W'(g - r0) : '0);
    assign tq[a]   = (dk[a] == '0) ? T_NEVER : T_W'(dquo[a]);

    always_comb begin
      unique case (st)
        F_DIV_T: begin
          dnum[a] = {g, 32'd0};
          dden[a] = dabs[a];
        end
        F_DIV_M: begin
          // positive step: far face; negative step: the voxel's own face
          dnum[a] = {(dk[a][KW-1] ? rs[a] : GE_W'(g - rs[a])), 32'd0};
          dden[a] = dabs[a];
        end
        default: begin
          dnum[a] = {{(DNUM_W-COORD_W){1'b0}}, mag};
          dden[a] = {{(DDEN_W-GE_W){1'b0}}, g};
        end
      endcase
    end

    vrt_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (go),
      .num   (dnum[a]),
      .den   (dden[a]),
      .done  (ddone[a]),
      .quo   (dquo[a]),
      .rem   (drem[a])
    );
  end

  always_comb begin
    q_data       = '0;
    q_data.span  = SPAN_W'({2'b0, dkabs[0]} + {2'b0, dkabs[1]} + {2'b0, dkabs[2]});
    q_data.empty = (dk == '0);
    q_data.ks    = ks;
    q_data.ke    = ke;
    q_data.tmax  = tmax;
    q_data.tdel  = tdel;
    for (int a = 0; a < 3; a++) q_data.neg[a] = dk[a][KW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
      go <= 1'b0;
    end else begin
      go <= go_next;
      unique case (st)
        F_IDLE: begin
          if (in_valid) begin
            s  <= {start_z, start_y, start_x};
            e  <= {end_z, end_y, end_x};
            st <= F_DIV_S;
          end
        end
        F_DIV_S: begin
          if (div_done) begin
            ks <= key;
            rs <= rfix;
            st <= F_DIV_E;
          end
        end
        F_DIV_E: begin
          if (div_done) begin
            ke <= key;
            st <= F_DIV_T;
          end
        end
        F_DIV_T: begin
          if (div_done) begin
            tdel <= tq;
            st   <= F_DIV_M;
          end
        end
        F_DIV_M: begin
          if (div_done) begin
            tmax <= tq;
            st   <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) st <= F_IDLE;
        end
        default: st <= F_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/vrt_queue.sv @@
// Two-entry queue between setup and walk.
module vrt_queue import vrt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wdata,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t rdata
);

  localparam int AW = $clog2(QDEPTH);

  entry_t        mem [QDEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   cnt;

  assign full  = (cnt == (AW+1)'(QDEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(QDEPTH - 1)) ? '0 : AW'(wp + 1'b1);
      if (pop)  rp <= (rp == AW'(QDEPTH - 1)) ? '0 : AW'(rp + 1'b1);
      cnt <= (AW+1)'(cnt + push - pop);
    end
  end

endmodule

@@ rtl/core/vrt_back.sv @@
// Back end: walks the DDA one iteration per cycle, holding while a result beat is stalled, and drives the result beats.
module vrt_back import vrt_pkg::*; #(
  parameter int MAX_STEPS = 64,
  parameter int KEY_BITS  = 23
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_empty,
  input  entry_t                  q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] voxel_x,
  output logic signed [OUT_W-1:0] voxel_y,
  output logic signed [OUT_W-1:0] voxel_z,
  output logic                    empty_ray,
  output logic                    truncated,
  output logic                    last
);

  localparam int NW = $clog2(MAX_STEPS + 1);
  localparam int IW = $clog2(2 * MAX_STEPS + 3);

  typedef enum logic [1:0] {B_IDLE, B_WALK, B_FLUSH} bstate_t;

  bstate_t st;
  logic [2:0][KW-1:0]   pos;
  logic [2:0][KW-1:0]   ke;
  logic [2:0]           neg;
  logic [2:0][T_W-1:0]  tmax;
  logic [2:0][T_W-1:0]  tdel;
  logic [ITER_W-1:0]    iters;
  logic [IW-1:0]        i;
  logic [NW-1:0]        n;
  // held item: whether a beat is the final one is only known at the next voxel or at the end of the walk
  logic                 pend_v;
  logic [2:0][KW-1:0]   pend;
  logic                 pend_empty;
  logic                 pend_trunc;

  logic                 slot_free;
  logic                 emit;
  logic                 stall;
  logic                 load_beat;
  logic [1:0]           ax;
  logic [T_W:0]         tsum;
  logic [T_W-1:0]       tnew;
  logic [2:0][T_W-1:0]  tmax_next;
  logic [2:0][KW-1:0]   pos_next;
  logic                 brk;
  logic [NW-1:0]        n_next;
  logic                 cap;
  logic [IW-1:0]        i_next;
  logic                 more;

  function automatic logic [OUT_W-1:0] key_out(input logic [KW-1:0] k);
    logic [KW-1:0] w;
    w = {{(KW-KEY_BITS){k[KEY_BITS-1]}}, k[KEY_BITS-1:0]};
    return w[OUT_W-1:0];
  endfunction

  assign slot_free = !out_valid || out_ready;
  assign q_pop     = (st == B_IDLE) && !q_empty;
  assign emit      = (pos != ke);
  assign stall     = emit && pend_v && !slot_free;
  assign load_beat = (st == B_WALK && !stall && emit && pend_v) ||
                     (st == B_FLUSH && slot_free);

  // ties go to z first, then y
  always_comb begin
    if (tmax[0] < tmax[1]) ax = (tmax[0] < tmax[2]) ? 2'd0 : 2'd2;
    else                   ax = (tmax[1] < tmax[2]) ? 2'd1 : 2'd2;
  end

  assign tsum = {1'b0, tmax[ax]} + {1'b0, tdel[ax]};
  assign tnew = tsum[T_W] ? T_NEVER : tsum[T_W-1:0];

  always_comb begin
    tmax_next     = tmax;
    tmax_next[ax] = tnew;
    pos_next      = pos;
    pos_next[ax]  = neg[ax] ? KW'(pos[ax] - 1'b1) : KW'(pos[ax] + 1'b1);
  end

  assign brk    = (tmax_next[0] > T_ONE) && (tmax_next[1] > T_ONE) && (tmax_next[2] > T_ONE);
  assign n_next = NW'(n + emit);
  assign cap    = emit && (n_next >= NW'(MAX_STEPS));
  assign i_next = IW'(i + 1'b1);
  assign more   = {{(ITER_W-IW){1'b0}}, i_next} < iters;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= B_IDLE;
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      if (load_beat)      out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (st)
        B_IDLE: begin
          if (!q_empty) begin
            pos        <= q_data.ks;
            ke         <= q_data.ke;
            neg        <= q_data.neg;
            tmax       <= q_data.tmax;
            tdel       <= q_data.tdel;
            iters      <= {q_data.span, 1'b1};
            i          <= '0;
            n          <= '0;
            pend_v     <= 1'b0;
            pend       <= '0;
            pend_empty <= q_data.empty;
            pend_trunc <= 1'b0;
            st         <= q_data.empty ? B_FLUSH : B_WALK;
          end
        end
        B_WALK: begin
          if (!stall) begin
            if (emit) begin
              if (pend_v) begin
                voxel_x   <= key_out(pend[0]);
                voxel_y   <= key_out(pend[1]);
                voxel_z   <= key_out(pend[2]);
                empty_ray <= 1'b0;
                truncated <= 1'b0;
                last      <= 1'b0;
              end
              pend   <= pos;
              pend_v <= 1'b1;
            end
            pos  <= pos_next;
            tmax <= tmax_next;
            n    <= n_next;
            i    <= i_next;
            if (brk || cap || !more) begin
              pend_trunc <= cap && !brk && more;
              st         <= B_FLUSH;
            end
          end
        end
        B_FLUSH: begin
          if (slot_free) begin
            voxel_x   <= key_out(pend[0]);
            voxel_y   <= key_out(pend[1]);
            voxel_z   <= key_out(pend[2]);
            empty_ray <= pend_empty;
            truncated <= pend_trunc;
            last      <= 1'b1;
            pend_v    <= 1'b0;
            st        <= B_IDLE;
          end
        end
        default: st <= B_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/voxel_ray_traversal.sv @@
// Voxel ray traversal top level: config register, setup front end, queue, walker.
//
// A ray (start and end point, signed Q16.16) enters on the in channel and leaves as
// one beat per voxel crossed, end voxel excluded, the final beat marked last; a
// ray whose end points share a voxel gives one beat flagged empty_ray. Setup runs
// four divisions in a row on one iterative divider per axis (start key, end key,
// step increment, first crossing), each yielding 53 quotient bits. The walker loads
// a ray, runs one DDA iteration per cycle and then closes the ray; it holds while a
// beat is waiting and out_ready is low. A two-entry queue lets the next ray's setup
// overlap the current walk. The grid size may be written only while no ray is in
// flight; a zero grid size counts as one.
module voxel_ray_traversal import vrt_pkg::*; #(
  parameter int MAX_STEPS = 64,
  parameter int KEY_BITS  = 23
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [GRID_W-1:0]         cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] start_z,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  input  logic signed [COORD_W-1:0] end_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [OUT_W-1:0]   voxel_x,
  output logic signed [OUT_W-1:0]   voxel_y,
  output logic signed [OUT_W-1:0]   voxel_z,
  output logic                      empty_ray,
  output logic                      truncated,
  output logic                      last
);

  logic [GRID_W-1:0] voxel_edge;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  entry_t            q_wdata;
  entry_t            q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      voxel_edge <= GRID_RESET;
    end else if (cfg_valid) begin
      voxel_edge <= cfg_data;
    end
  end

  vrt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .voxel_edge (voxel_edge),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .start_x    (start_x),
    .start_y    (start_y),
    .start_z    (start_z),
    .end_x      (end_x),
    .end_y      (end_y),
    .end_z      (end_z),
    .q_push     (q_push),
    .q_full     (q_full),
    .q_data     (q_wdata)
  );

  vrt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  vrt_back #(
    .MAX_STEPS (MAX_STEPS),
    .KEY_BITS  (KEY_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .voxel_x   (voxel_x),
    .voxel_y   (voxel_y),
    .voxel_z   (voxel_z),
    .empty_ray (empty_ray),
    .truncated (truncated),
    .last      (last)
  );

endmodule

@@ rtl/core/vrt_checker.sv @@
// Port-level checks for the voxel ray traversal block, bound to the top level.
module vrt_checker import vrt_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] voxel_x,
  input logic signed [OUT_W-1:0] voxel_y,
  input logic signed [OUT_W-1:0] voxel_z,
  input logic                    empty_ray,
  input logic                    truncated,
  input logic                    last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(voxel_x) && $stable(last))
    else $error("result beat changed while stalled");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_ray |-> last && !truncated)
    else $error("empty ray beat not a lone final beat");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_ray |-> voxel_x == '0 && voxel_y == '0 && voxel_z == '0)
    else $error("empty ray beat carries a voxel");

  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && truncated |-> last)
    else $error("truncated flag on a non-final beat");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (.*);

@@ bench/voxel_ray_traversal_tb.sv @@
// Testbench for voxel_ray_traversal: random and directed rays checked against a DDA predictor.
`timescale 1ns / 100ps

module voxel_ray_traversal_tb;
  import vrt_pkg::*;

  localparam int MAX_VOX = 64;
  localparam int KEYB = 23;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [OUT_W-1:0] vx;
    logic [OUT_W-1:0] vy;
    logic [OUT_W-1:0] vz;
    logic             empty;
    logic             trunc;
    logic             lst;
  } voxel_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [GRID_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] start_x = '0, start_y = '0, start_z = '0;
  logic signed [COORD_W-1:0] end_x = '0, end_y = '0, end_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] voxel_x, voxel_y, voxel_z;
  logic empty_ray, truncated, last;

  voxel_ray_traversal dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [GRID_W-1:0] grid_reg = GRID_RESET;
  voxel_beat_t expected_voxels[$];
  int errors = 0;
  int hold_off = 0;
  bit stall_mode = 1'b0;
  int idle_cycles = 0;

  task automatic report(input string what, input voxel_beat_t got, input voxel_beat_t want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint floor_by(input longint a, input longint g);
    longint q;
    q = a / g;
    if ((a % g) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic logic [63:0] q32_div(input logic [63:0] num, input logic [63:0] den);
    logic [127:0] wide;
    if (den == 0) return T_NEVER;
    wide = {64'd0, num} << 32;
    return 64'(wide / den);
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = a + b;
    return s[64] ? T_NEVER : s[63:0];
  endfunction

  function automatic logic [OUT_W-1:0] wrap_key(input longint k);
    logic [KEYB-1:0] w;
    w = k[KEYB-1:0];
    return OUT_W'(signed'(w));
  endfunction

  // walk one ray and queue every voxel it should yield
  task automatic predict_voxels(input logic signed [31:0] p[6]);
    longint g, s[3], e[3], ks[3], ke[3], pos[3], stp[3], span, iters, dk, d;
    logic [63:0] tm[3], td[3], dabs;
    voxel_beat_t b, walk[$];
    int ax;
    bit hit;
    g = (grid_reg == 0) ? 1 : longint'(grid_reg);
    span = 0;
    for (int a = 0; a < 3; a++) begin
      s[a] = p[a];
      e[a] = p[a+3];
      ks[a] = floor_by(s[a], g);
      ke[a] = floor_by(e[a], g);
      dk = ke[a] - ks[a];
      span += (dk < 0) ? -dk : dk;
      d = e[a] - s[a];
      dabs = (d < 0) ? -d : d;
      stp[a] = (dk >= 0) ? 1 : -1;
      pos[a] = ks[a];
      if (dk == 0) begin
        tm[a] = T_NEVER;
        td[a] = T_NEVER;
      end else begin
        td[a] = q32_div(g, dabs);
        tm[a] = (dk > 0) ? q32_div((ks[a] + 1) * g - s[a], dabs)
                         : q32_div(s[a] - ks[a] * g, dabs);
      end
    end
    if (span == 0) begin
      b = '0;
      b.empty = 1'b1;
      b.lst = 1'b1;
      expected_voxels.insert(expected_voxels.size(), b);
      return;
    end
    iters = span * 2 + 1;
    for (longint i = 0; i < iters; i++) begin
      hit = 1'b0;
      if (pos[0] != ke[0] || pos[1] != ke[1] || pos[2] != ke[2]) begin
        b = '0;
        b.vx = wrap_key(pos[0]);
        b.vy = wrap_key(pos[1]);
        b.vz = wrap_key(pos[2]);
        walk.insert(walk.size(), b);
        hit = 1'b1;
      end
      if (tm[0] < tm[1]) ax = (tm[0] < tm[2]) ? 0 : 2;
      else ax = (tm[1] < tm[2]) ? 1 : 2;
      pos[ax] += stp[ax];
      tm[ax] = add_sat(tm[ax], td[ax]);
      if (tm[0] > T_ONE && tm[1] > T_ONE && tm[2] > T_ONE) break;
      if (hit && walk.size() >= MAX_VOX) begin
        if (i + 1 < iters) walk[walk.size()-1].trunc = 1'b1;
        break;
      end
    end
    walk[walk.size()-1].lst = 1'b1;
    foreach (walk[k]) expected_voxels.insert(expected_voxels.size(), walk[k]);
  endtask

  // output checker
  always @(posedge clk) begin
    voxel_beat_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {voxel_x, voxel_y, voxel_z, empty_ray, truncated, last};
      if (expected_voxels.size() == 0) begin
        report("unexpected beat", got, '0);
      end else begin
        want = expected_voxels.pop_front();
        if (got.vx !== want.vx) report("voxel_x", got, want);
        if (got.vy !== want.vy) report("voxel_y", got, want);
        if (got.vz !== want.vz) report("voxel_z", got, want);
        if (got.empty !== want.empty) report("empty_ray", got, want);
        if (got.trunc !== want.trunc) report("truncated", got, want);
        if (got.lst !== want.lst) report("last", got, want);
      end
    end
  end

  // receiver stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (stall_mode) begin
      out_ready <= ($urandom_range(0, 9) < 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || hold_off > 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_LIMIT) begin
      $display("voxel_ray_traversal_tb: errors");
      $finish;
    end
  end

  int burst_left = 0;

  // valid stays up across a burst; it drops only for a gap or a drain
  task automatic send_ray(input logic signed [31:0] p[6]);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    predict_voxels(p);
    in_valid <= 1'b1;
    start_x <= p[0]; start_y <= p[1]; start_z <= p[2];
    end_x <= p[3]; end_y <= p[4]; end_z <= p[5];
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_voxels.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_grid(input logic [GRID_W-1:0] g);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= g;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    grid_reg = g;
  endtask

  // short ray near a random point; span bounded to keep walks small
  task automatic short_ray(input int reach);
    logic signed [31:0] p[6];
    for (int a = 0; a < 3; a++) begin
      p[a] = $urandom;
      if ($urandom_range(0, 3) != 0) p[a] = signed'(p[a]) >>> $urandom_range(4, 14);
      p[a+3] = p[a] + $signed($urandom_range(0, 2 * reach)) - reach;
    end
    send_ray(p);
  endtask

  task automatic test_directed();
    logic signed [31:0] p[6];
    int g;
    g = 13107;
    p = '{0, 0, 0, 0, 0, 0}; send_ray(p);                       // zero-length
    p = '{0, 0, 0, 5 * g, 0, 0}; send_ray(p);                   // +x
    p = '{0, 0, 0, 0, -5 * g, 0}; send_ray(p);                  // -y, own face
    p = '{0, 0, 0, 0, 0, 3 * g}; send_ray(p);
    p = '{0, 0, 0, 3 * g, 3 * g, 3 * g}; send_ray(p);           // ties
    p = '{g / 2, g / 2, g / 2, -3 * g - 7, 2 * g + 9, -g}; send_ray(p);
    p = '{0, 0, 0, 200 * g, 0, 0}; send_ray(p);                 // step cap
    p = '{-5, 0, 0, 63 * g + 10, 0, 0}; send_ray(p);
    p = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh8000_0000 + 3 * g, 32'sh8000_0000, 32'sh8000_0000 - 2 * g}; send_ray(p);
    p = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF - 4 * g, 32'sh7FFF_FFFF - g, 32'sh7FFF_FFFF}; send_ray(p);
    p = '{32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0}; send_ray(p); // huge span
    p = '{-1, -1, -1, 1, 1, 1}; send_ray(p);
    p = '{0, 0, 0, -1, -1, -1}; send_ray(p);
    p = '{32'shFFFF_0000, 32'sh0000_FFFF, 32'shAAAA_AAAA,
          32'shFFFF_0000, 32'sh0000_FFFF, 32'sh5555_5555}; send_ray(p);
  endtask

  task automatic test_random_rays(input int n, input int reach);
    logic signed [31:0] p[6];
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        foreach (p[k]) p[k] = $urandom;
        send_ray(p);
      end else begin
        short_ray(reach);
      end
    end
  endtask

  task automatic test_grid_settings();
    write_grid(20'd655);
    test_random_rays(25, 6000);
    write_grid(20'hFFFFF);
    test_random_rays(25, 4000000);
    write_grid(20'd655360);
    test_random_rays(25, 3000000);
    write_grid(20'd0);
    test_random_rays(10, 40);
    write_grid(GRID_W'($urandom_range(655, 655360)));
    test_random_rays(25, 500000);
    write_grid(GRID_RESET);
  endtask

  task automatic test_backpressure();
    drain();
    hold_off = 1500;
    test_random_rays(8, 60000);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    stall_mode = 1'b1;
    test_random_rays(150, 80000);
    test_backpressure();
    test_grid_settings();
    stall_mode = 1'b0;
    test_random_rays(90, 80000);
    drain();
    if (errors == 0) $display("voxel_ray_traversal_tb: clean");
    else $display("voxel_ray_traversal_tb: errors");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/vrt_pkg.sv
rtl/core/vrt_div.sv
rtl/core/vrt_front.sv
rtl/core/vrt_queue.sv
rtl/core/vrt_back.sv
rtl/core/voxel_ray_traversal.sv
rtl/core/vrt_checker.sv
bench/voxel_ray_traversal_tb.sv
